### rtl/mtf_pkg.sv
// shared constants, codes and word types for the move-to-front rank core
// no dependencies; imported by mtf_cell and move_to_front_rank_core
package mtf_pkg;

   // list and slot geometry
   localparam int MAX_ITEMS   = 1024;
   localparam int ITEM_W      = 11;
   localparam int IDX_W       = 10;
   localparam int SLOT_W      = 12;
   localparam int LEVELS      = SLOT_W;
   localparam int FRONT_SLOTS = 3072;
   localparam int COUNT_W     = 11;
   localparam int RANK_W      = 10;
   localparam int STATUS_W    = 2;

   // operation codes
   localparam logic OP_QUERY   = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ITEM  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic              operation;
      logic [ITEM_W-1:0] item;
   } mtf_req_type;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [STATUS_W-1:0] status;
   } mtf_rsp_type;

   // token walking down the row of level cells
   // old_* carries the current slot (or the leaf index during a sweep),
   // new_* the fresh front slot; *_pfx is the node at the last level seen,
   // *_rest the slot bits still to be consumed, msb first
   typedef struct packed {
      logic               valid;
      logic               sweep;
      logic               last;
      logic               occ;
      logic [SLOT_W-1:0]  old_pfx;
      logic [SLOT_W-1:0]  old_rest;
      logic [SLOT_W-1:0]  new_pfx;
      logic [SLOT_W-1:0]  new_rest;
      logic [COUNT_W-1:0] sum;
   } mtf_token_type;

endpackage

### rtl/mtf_ram.sv
// simple dual-port ram: one write port, one registered read port
// no dependencies
module mtf_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mtf_cell.sv
// one level of the counting tree: walks a token one level down, adds the
// left-sibling count to the prefix sum, updates old and new path nodes or
// loads sweep counts; depends on mtf_pkg; its count ram sits beside it in the top level
module mtf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  mtf_pkg::mtf_token_type        tok_i,
   output mtf_pkg::mtf_token_type        tok_o,
   output logic [mtf_pkg::SLOT_W-1:0]    rd_addr_o,
   input  logic [mtf_pkg::COUNT_W-1:0]   rd_data_i,
   output logic                          wr_en_o,
   output logic [mtf_pkg::SLOT_W-1:0]    wr_addr_o,
   output logic [mtf_pkg::COUNT_W-1:0]   wr_data_o
);
   import mtf_pkg::*;

   mtf_token_type      adv;
   mtf_token_type      s1_ff;
   mtf_token_type      s1_in;
   mtf_token_type      s2_ff;
   mtf_token_type      s2_in;
   logic               s3_valid_ff;
   logic               s3_valid_in;
   logic [SLOT_W-1:0]  s3_node_ff;
   logic [COUNT_W-1:0] acc_ff;
   logic [COUNT_W-1:0] acc_in;
   logic [SLOT_W-1:0]  old_node;
   logic [SLOT_W-1:0]  new_node;
   logic               run_start;
   logic [COUNT_W-1:0] sweep_count;
   logic [COUNT_W-1:0] sum1;
   logic               same_node;
   logic               in_query;
   logic               in_sweep;
   logic               s1_query;
   logic               s2_query;

   // node index at this level for both paths
   assign old_node = {tok_i.old_pfx[SLOT_W-2:0], tok_i.old_rest[SLOT_W-1]};
   assign new_node = {tok_i.new_pfx[SLOT_W-2:0], tok_i.new_rest[SLOT_W-1]};

   assign in_query = tok_i.valid && !tok_i.sweep;
   assign in_sweep = tok_i.valid && tok_i.sweep;
   assign s1_query = s1_ff.valid && !s1_ff.sweep;
   assign s2_query = s2_ff.valid && !s2_ff.sweep;

   // sweep: leaves arrive in ascending order, a node's run starts when
   // the leaf bits below it are all zero
   assign run_start   = (tok_i.old_rest[SLOT_W-2:0] == '0);
   assign sweep_count = (run_start ? '0 : acc_ff) + COUNT_W'(tok_i.occ);

   // token advanced by one level
   always_comb begin
      adv          = tok_i;
      adv.old_pfx  = old_node;
      adv.old_rest = tok_i.old_rest << 1;
      adv.new_pfx  = new_node;
      adv.new_rest = tok_i.new_rest << 1;
   end
   assign s1_in = adv;

   // prefix sum picks up the left sibling when the path goes right
   assign sum1 = s1_ff.sum + ((s1_query && s1_ff.old_pfx[0]) ? rd_data_i : '0);
   always_comb begin
      s2_in     = s1_ff;
      s2_in.sum = sum1;
   end

   // paths that share a node leave it unchanged
   assign same_node   = (s2_ff.old_pfx == s2_ff.new_pfx);
   assign s3_valid_in = s2_query && !same_node;

   assign acc_in = in_sweep ? sweep_count : acc_ff;

   // read port: sibling, then old node, then new node
   always_comb begin
      if (in_query) begin
         rd_addr_o = old_node ^ SLOT_W'(1);
      end else if (s1_query) begin
         rd_addr_o = s1_ff.old_pfx;
      end else if (s2_query) begin
         rd_addr_o = s2_ff.new_pfx;
      end else begin
         rd_addr_o = '0;
      end
   end

   // write port: sweep load, old node minus one, new node plus one
   always_comb begin
      wr_en_o   = 1'b0;
      wr_addr_o = s3_node_ff;
      wr_data_o = rd_data_i + COUNT_W'(1);
      if (in_sweep) begin
         wr_en_o   = 1'b1;
         wr_addr_o = old_node;
         wr_data_o = sweep_count;
      end else if (s3_valid_in) begin
         wr_en_o   = 1'b1;
         wr_addr_o = s2_ff.old_pfx;
         wr_data_o = rd_data_i - COUNT_W'(1);
      end else if (s3_valid_ff) begin
         wr_en_o = 1'b1;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s3_node_ff <= s2_ff.new_pfx;
      acc_ff     <= acc_in;
   end

   assign tok_o = s2_ff;

endmodule

### rtl/move_to_front_rank_core.sv
// move-to-front rank core: a query raises rsp_valid after lookup, inject, a walk through
// the stage registers of the 12 level cells and the reply state; one word at a time;
// out-of-range and exhausted queries skip the walk and go straight to the reply state
// restart and reset run a load pass over all 4096 leaves, during which no word is
// accepted; reset sends no response word
// depends on mtf_pkg, mtf_ram, mtf_cell
module move_to_front_rank_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mtf_pkg::mtf_req_type          req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mtf_pkg::mtf_rsp_type          rsp_word,
   input  logic                          csr_wr_en,
   input  logic [mtf_pkg::ITEM_W-1:0]    csr_wr_data
);
   import mtf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WALK,
      ST_SWEEP,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   state_type          state_ff, state_in;
   logic [ITEM_W-1:0]  count_cfg_ff, count_cfg_in;
   logic [ITEM_W-1:0]  loaded_ff, loaded_in;
   logic [SLOT_W-1:0]  next_front_ff, next_front_in;
   logic               exhausted_ff, exhausted_in;
   logic [SLOT_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic               reply_sweep_ff, reply_sweep_in;
   mtf_token_type      inj_ff, inj_in;
   logic [IDX_W-1:0]   item_idx_ff, item_idx_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mtf_rsp_type        rsp_word_ff, rsp_word_in;

   logic [ITEM_W-1:0]  count_clamped;
   logic [ITEM_W-1:0]  item_minus_one;
   logic               req_take;
   logic [SLOT_W-1:0]  leaf_off;
   logic               leaf_occ;
   logic               slot_wr_en;
   logic [IDX_W-1:0]   slot_wr_addr;
   logic [SLOT_W-1:0]  slot_wr_data;
   logic [SLOT_W-1:0]  slot_rd_data;
   mtf_token_type      tail;

   mtf_token_type      tok_chain   [LEVELS+1];
   logic [SLOT_W-1:0]  lvl_rd_addr [LEVELS];
   logic [COUNT_W-1:0] lvl_rd_data [LEVELS];
   logic               lvl_wr_en   [LEVELS];
   logic [SLOT_W-1:0]  lvl_wr_addr [LEVELS];
   logic [COUNT_W-1:0] lvl_wr_data [LEVELS];

   // item count as loaded by a restart
   assign count_clamped = (count_cfg_ff == '0) ? ITEM_W'(1) :
                          (count_cfg_ff > ITEM_W'(MAX_ITEMS)) ? ITEM_W'(MAX_ITEMS) :
                          count_cfg_ff;

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_take       = req_valid && req_ready;
   assign item_minus_one = req_word.item - ITEM_W'(1);

   // leaf occupancy for the load pass
   assign leaf_off = sweep_cnt_ff - SLOT_W'(FRONT_SLOTS);
   assign leaf_occ = (sweep_cnt_ff >= SLOT_W'(FRONT_SLOTS)) &&
                     (leaf_off < SLOT_W'(loaded_ff));

   // slot table writes: load pass or move to front
   always_comb begin
      slot_wr_en   = 1'b0;
      slot_wr_addr = item_idx_ff;
      slot_wr_data = next_front_ff;
      if (state_ff == ST_SWEEP) begin
         slot_wr_en   = (sweep_cnt_ff < SLOT_W'(MAX_ITEMS));
         slot_wr_addr = sweep_cnt_ff[IDX_W-1:0];
         slot_wr_data = SLOT_W'(FRONT_SLOTS) + sweep_cnt_ff;
      end else if (state_ff == ST_LOOKUP) begin
         slot_wr_en = 1'b1;
      end
   end

   mtf_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (item_minus_one[IDX_W-1:0]),
      .rd_data (slot_rd_data)
   );

   // row of level cells, level g+1 owns 2**(g+1) nodes
   assign tok_chain[0] = inj_ff;
   for (genvar g = 0; g < LEVELS; g++) begin : g_level
      mtf_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_i     (tok_chain[g]),
         .tok_o     (tok_chain[g+1]),
         .rd_addr_o (lvl_rd_addr[g]),
         .rd_data_i (lvl_rd_data[g]),
         .wr_en_o   (lvl_wr_en[g]),
         .wr_addr_o (lvl_wr_addr[g]),
         .wr_data_o (lvl_wr_data[g])
      );

      mtf_ram #(
         .ADDR_W (g + 1),
         .DATA_W (COUNT_W)
      ) u_count_ram (
         .clock   (clock),
         .wr_en   (lvl_wr_en[g]),
         .wr_addr (lvl_wr_addr[g][g:0]),
         .wr_data (lvl_wr_data[g]),
         .rd_addr (lvl_rd_addr[g][g:0]),
         .rd_data (lvl_rd_data[g])
      );
   end
   assign tail = tok_chain[LEVELS];

   // control and next-state logic
   always_comb begin
      state_in       = state_ff;
      count_cfg_in   = csr_wr_en ? csr_wr_data : count_cfg_ff;
      loaded_in      = loaded_ff;
      next_front_in  = next_front_ff;
      exhausted_in   = exhausted_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      reply_sweep_in = reply_sweep_ff;
      item_idx_in    = item_idx_ff;
      rank_in        = rank_ff;
      status_in      = status_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      inj_in          = '0;
      inj_in.old_rest = slot_rd_data;
      inj_in.new_rest = next_front_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rank_in   = '0;
               status_in = STATUS_OK;
               if (req_word.operation == OP_RESTART) begin
                  loaded_in      = count_clamped;
                  next_front_in  = SLOT_W'(FRONT_SLOTS - 1);
                  exhausted_in   = 1'b0;
                  sweep_cnt_in   = '0;
                  reply_sweep_in = 1'b1;
                  state_in       = ST_SWEEP;
               end else if ((req_word.item == '0) || (req_word.item > loaded_ff)) begin
                  status_in = STATUS_BAD_ITEM;
                  state_in  = ST_REPLY;
               end else if (exhausted_ff) begin
                  status_in = STATUS_EXHAUSTED;
                  state_in  = ST_REPLY;
               end else begin
                  item_idx_in = item_minus_one[IDX_W-1:0];
                  state_in    = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            // launch the walk, hand out the fresh front slot
            inj_in.valid = 1'b1;
            if (next_front_ff == '0) begin
               exhausted_in = 1'b1;
            end else begin
               next_front_in = next_front_ff - SLOT_W'(1);
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (tail.valid && !tail.sweep) begin
               rank_in  = tail.sum[RANK_W-1:0];
               state_in = ST_REPLY;
            end
         end
         ST_SWEEP: begin
            inj_in.valid    = 1'b1;
            inj_in.sweep    = 1'b1;
            inj_in.occ      = leaf_occ;
            inj_in.last     = (sweep_cnt_ff == '1);
            inj_in.old_rest = sweep_cnt_ff;
            inj_in.new_rest = '0;
            sweep_cnt_in    = sweep_cnt_ff + SLOT_W'(1);
            if (sweep_cnt_ff == '1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (tail.valid && tail.sweep && tail.last) begin
               state_in = reply_sweep_ff ? ST_REPLY : ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_word_in.rank   = rank_ff;
               rsp_word_in.status = status_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         count_cfg_ff   <= ITEM_W'(MAX_ITEMS);
         loaded_ff      <= ITEM_W'(MAX_ITEMS);
         next_front_ff  <= SLOT_W'(FRONT_SLOTS - 1);
         exhausted_ff   <= 1'b0;
         sweep_cnt_ff   <= '0;
         reply_sweep_ff <= 1'b0;
         inj_ff.valid   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_cfg_ff   <= count_cfg_in;
         loaded_ff      <= loaded_in;
         next_front_ff  <= next_front_in;
         exhausted_ff   <= exhausted_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         reply_sweep_ff <= reply_sweep_in;
         inj_ff         <= inj_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_idx_ff <= item_idx_in;
      rank_ff     <= rank_in;
      status_ff   <= status_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a finished walk only shows up while the controller waits for it
   assert property (@(posedge clock) disable iff (reset)
      (tail.valid && !tail.sweep) |-> (state_ff == ST_WALK))
      else $error("walk result outside of walk state");

   // a rank is always below the number of loaded items
   assert property (@(posedge clock) disable iff (reset)
      (tail.valid && !tail.sweep) |-> (tail.sum < loaded_ff))
      else $error("rank not below loaded item count");

   // front slots are exhausted only after slot zero went out
   assert property (@(posedge clock) disable iff (reset)
      exhausted_ff |-> (next_front_ff == '0))
      else $error("front exhausted with slots left");

endmodule

### test/tb.sv
// self-checking bench for move_to_front_rank_core: directed and random words
// against a list-order predictor; depends on mtf_pkg and the core rtl
`timescale 1ns / 100ps

module tb;
   import mtf_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int IDLE_MAX = 17;
   localparam int RANDOM_PHASES = 6;
   localparam int WORDS_PER_PHASE = 108;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   mtf_req_type         req_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   mtf_rsp_type         rsp_word;
   logic                csr_wr_en = 1'b0;
   logic [ITEM_W-1:0]   csr_wr_data = '0;

   // predictor state: list front at index 0, item numbers from 1
   int                  list_order[$];
   int                  loaded_items;
   int                  fresh_left;
   logic [ITEM_W-1:0]   count_setting;
   mtf_rsp_type         pending_answers[$];
   bit                  last_was_restart = 1'b1;

   int                  req_idle_max = IDLE_MAX;
   int                  rsp_idle_max = IDLE_MAX;
   int                  rsp_stall_left = 0;
   int                  cycle_count = 0;
   int                  answer_errors = 0;
   int                  n_ok = 0;
   int                  n_bad = 0;
   int                  n_exhausted = 0;
   int                  n_restarts = 0;

   move_to_front_rank_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // reload the starting order for the current count setting
   function automatic void reload_list();
      int n;
      n = int'(count_setting);
      if (n == 0) n = 1;
      if (n > MAX_ITEMS) n = MAX_ITEMS;
      loaded_items = n;
      list_order.delete();
      for (int i = 1; i <= n; i++) list_order.push_back(i);
      fresh_left = FRONT_SLOTS;
   endfunction

   // answer for one accepted word, then apply the move to front
   function automatic mtf_rsp_type rank_and_move(mtf_req_type w);
      mtf_rsp_type ans;
      int pos;
      ans = '0;
      pos = 0;
      if (w.operation == OP_RESTART) begin
         reload_list();
         ans.status = STATUS_OK;
         n_restarts++;
      end else if (w.item == 0 || w.item > loaded_items) begin
         ans.status = STATUS_BAD_ITEM;
         n_bad++;
      end else if (fresh_left == 0) begin
         ans.status = STATUS_EXHAUSTED;
         n_exhausted++;
      end else begin
         while (list_order[pos] != w.item) pos++;
         list_order.delete(pos);
         list_order.push_front(w.item);
         fresh_left--;
         ans.rank = pos[RANK_W-1:0];
         ans.status = STATUS_OK;
         n_ok++;
      end
      return ans;
   endfunction

   // valid query item, biased toward the front and the back of the list
   function automatic logic [ITEM_W-1:0] pick_item();
      int sel;
      int span;
      sel = $urandom_range(0, 99);
      span = (list_order.size() > 16) ? 16 : list_order.size();
      if (sel < 45) return ITEM_W'(list_order[$urandom_range(0, span - 1)]);
      if (sel < 52) return ITEM_W'(list_order[list_order.size() - 1]);
      return ITEM_W'($urandom_range(1, loaded_items));
   endfunction

   // item number outside the loaded range
   function automatic logic [ITEM_W-1:0] pick_bad_item();
      if ($urandom_range(0, 3) == 0) return '0;
      return ITEM_W'($urandom_range(loaded_items + 1, (1 << ITEM_W) - 1));
   endfunction

   // send one word; starts and returns on a falling edge, valid left high
   task automatic send_word(input logic op, input logic [ITEM_W-1:0] item_no);
      int gap;
      mtf_req_type w;
      gap = $urandom_range(0, req_idle_max);
      w.operation = op;
      w.item = item_no;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(rank_and_move(w));
      last_was_restart = (op == OP_RESTART);
      @(negedge clock);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   // register write only with the core idle; a restart load pass is flushed
   // by a cheap out-of-range query that cannot be taken until the pass ends
   task automatic set_item_count(input logic [ITEM_W-1:0] value);
      wait_for_answers();
      if (last_was_restart) begin
         send_word(OP_QUERY, '0);
         wait_for_answers();
      end
      repeat (32) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      count_setting = value;
   endtask

   // list as left by reset: full 1024 items, both operations
   task automatic test_reset_state();
      send_word(OP_QUERY, 11'd1);
      send_word(OP_QUERY, 11'd1024);
      send_word(OP_QUERY, 11'd0);
      send_word(OP_QUERY, 11'd1025);
      send_word(OP_QUERY, 11'd2047);
      send_word(OP_QUERY, 11'd512);
      send_word(OP_QUERY, 11'd1024);
      send_word(OP_RESTART, 11'd2047);
      send_word(OP_QUERY, 11'd1024);
   endtask

   // count register at and beyond its limits
   task automatic test_item_count_limits();
      set_item_count(11'd0);
      send_word(OP_RESTART, 11'd0);
      send_word(OP_QUERY, 11'd1);
      send_word(OP_QUERY, 11'd2);
      send_word(OP_QUERY, 11'd1);
      set_item_count(11'd2047);
      send_word(OP_RESTART, 11'd5);
      send_word(OP_QUERY, 11'd1024);
      send_word(OP_QUERY, 11'd1025);
      set_item_count(11'd1);
      send_word(OP_RESTART, 11'd0);
      send_word(OP_QUERY, 11'd1);
      send_word(OP_QUERY, 11'd0);
      set_item_count(11'd1024);
      send_word(OP_RESTART, 11'd1024);
      send_word(OP_QUERY, 11'd1000);
   endtask

   // use up every fresh front slot, then probe the exhausted state
   task automatic test_front_exhaustion();
      req_idle_max = 0;
      rsp_idle_max = 0;
      send_word(OP_RESTART, 11'd0);
      repeat (FRONT_SLOTS) send_word(OP_QUERY, pick_item());
      send_word(OP_QUERY, 11'd1);
      send_word(OP_QUERY, 11'd1024);
      // out-of-range takes priority over exhaustion
      send_word(OP_QUERY, 11'd0);
      send_word(OP_QUERY, 11'd1500);
      send_word(OP_RESTART, 11'd0);
      send_word(OP_QUERY, 11'd1024);
      req_idle_max = IDLE_MAX;
      rsp_idle_max = IDLE_MAX;
   endtask

   // random phases: count setting, restart, then mostly valid queries
   task automatic test_random_traffic();
      int sel;
      logic [ITEM_W-1:0] setting;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: setting = 11'd1024;
            1: setting = ITEM_W'($urandom_range(2, 1023));
            2: setting = 11'd1;
            3: setting = ITEM_W'($urandom_range(1025, 2047));
            4: setting = ITEM_W'($urandom_range(2, 64));
            default: setting = ITEM_W'($urandom_range(0, 1024));
         endcase
         set_item_count(setting);
         req_idle_max = (phase % 3 == 2) ? 0 : IDLE_MAX;
         rsp_idle_max = (phase % 3 == 1) ? 0 : IDLE_MAX;
         send_word(OP_RESTART, ITEM_W'($urandom_range(0, 2047)));
         repeat (WORDS_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            if (sel < 4) send_word(OP_RESTART, ITEM_W'($urandom_range(0, 2047)));
            else if (sel < 11) send_word(OP_QUERY, pick_bad_item());
            else send_word(OP_QUERY, pick_item());
         end
      end
      req_idle_max = IDLE_MAX;
      rsp_idle_max = IDLE_MAX;
   endtask

   // result side stall per word
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each answer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $error("answer with none pending: rank %0d status %0d",
                   rsp_word.rank, rsp_word.status);
            answer_errors++;
         end else begin
            mtf_rsp_type exp_ans;
            exp_ans = pending_answers.pop_front();
            if (rsp_word.rank !== exp_ans.rank) begin
               $error("rank: expected %0d, actual %0d", exp_ans.rank, rsp_word.rank);
               answer_errors++;
            end
            if (rsp_word.status !== exp_ans.status) begin
               $error("status: expected %0d, actual %0d",
                      exp_ans.status, rsp_word.status);
               answer_errors++;
            end
         end
         rsp_stall_left = $urandom_range(0, rsp_idle_max);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers pending",
                  cycle_count, pending_answers.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      count_setting = 11'd1024;
      reload_list();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_item_count_limits();
      test_front_exhaustion();
      test_random_traffic();
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d answers never arrived", pending_answers.size());
         answer_errors++;
      end
      $display("covered %0d moves, %0d restarts, %0d out-of-range, %0d exhausted",
               n_ok, n_restarts, n_bad, n_exhausted);
      $display("in %0d cycles with %0d mismatches", cycle_count, answer_errors);
      if (answer_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
rtl/mtf_pkg.sv
rtl/mtf_ram.sv
rtl/mtf_cell.sv
rtl/move_to_front_rank_core.sv
test/tb.sv
